// ----- rtl/core/csd_pkg.sv -----
package csd_pkg;

   // store geometry and element width
   localparam int MAX_ELEMENTS = 16;
   localparam int VALUE_BITS   = 16;
   localparam int IDX_BITS     = $clog2(MAX_ELEMENTS);
   localparam int CNT_BITS     = $clog2(MAX_ELEMENTS + 1);

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DN_INIT,
      ST_DN_CARRY,
      ST_DN_STEP,
      ST_DN_FLUSH,
      ST_UP_INIT,
      ST_UP_CARRY,
      ST_UP_STEP,
      ST_UP_FLUSH,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

endpackage

// ----- rtl/core/cocktail_sort_descending.sv -----
// Collects a set of unsigned words, one per accepted req_ word, until a word with req_last
// set; up to 16 words are kept and later ones are dropped, though their last flag still
// closes the set. The set is then sorted largest first by cocktail shaker passes and sent
// out on rsp_, one word per element, with rsp_final_res on the final one. While loading,
// req_stall is low and each valid word is taken. The sort runs through a single-port-read,
// single-port-write element memory with one read-modify-write per cycle: a set of n words
// (n of two or more) takes n*(n-1)/2 compare steps at one per cycle, plus an init, a carry
// and a flush state on each of the n-1 passes; a single word skips the sort.
// Each result is read from memory, then loaded into the output register once that is free.
// req_stall is high from the last word of a set until its final result has been loaded
// into the output register.
module cocktail_sort_descending
   import csd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_sorted_value,
   output logic                  rsp_final_res
);

   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_ELEMENTS);

   // element memory
   logic [VALUE_BITS-1:0] mem [MAX_ELEMENTS];
   logic [VALUE_BITS-1:0] rdata_ff;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [VALUE_BITS-1:0] wr_data;

   // control and datapath registers
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   left_ff, left_in;
   logic [CNT_BITS-1:0]   right_ff, right_in;
   logic [CNT_BITS-1:0]   pass_ff, pass_in;
   logic [IDX_BITS-1:0]   emit_idx_ff, emit_idx_in;
   logic [VALUE_BITS-1:0] carry_ff, carry_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_final_ff, rsp_final_in;

   // helper arithmetic
   logic                  req_accept;
   logic [CNT_BITS-1:0]   count_next;
   logic [CNT_BITS-1:0]   count_m1;
   logic [CNT_BITS-1:0]   pass_m1, pass_m2, pass_p1;
   logic [CNT_BITS-1:0]   left_m1, left_p1, right_m1;
   logic                  emit_final;

   assign req_accept = req_valid && !req_stall;
   assign count_next = (count_ff < CNT_MAX) ? count_ff + CNT_ONE : count_ff;
   assign count_m1   = count_ff - CNT_ONE;
   assign pass_m1    = pass_ff - CNT_ONE;
   assign pass_m2    = pass_ff - CNT_BITS'(2);
   assign pass_p1    = pass_ff + CNT_ONE;
   assign left_m1    = left_ff - CNT_ONE;
   assign left_p1    = left_ff + CNT_ONE;
   assign right_m1   = right_ff - CNT_ONE;
   assign emit_final = ({1'b0, emit_idx_ff} == count_m1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_last) begin
               state_in = (count_next < CNT_BITS'(2)) ? ST_EMIT_RD : ST_DN_INIT;
            end
         end
         ST_DN_INIT:  state_in = ST_DN_CARRY;
         ST_DN_CARRY: state_in = ST_DN_STEP;
         ST_DN_STEP: begin
            if (pass_ff == left_ff) begin
               state_in = ST_DN_FLUSH;
            end
         end
         ST_DN_FLUSH: state_in = (left_p1 > right_ff) ? ST_EMIT_RD : ST_UP_INIT;
         ST_UP_INIT:  state_in = ST_UP_CARRY;
         ST_UP_CARRY: state_in = ST_UP_STEP;
         ST_UP_STEP: begin
            if (pass_ff == right_ff) begin
               state_in = ST_UP_FLUSH;
            end
         end
         ST_UP_FLUSH: state_in = (left_ff <= right_m1) ? ST_DN_INIT : ST_EMIT_RD;
         ST_EMIT_RD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD:  state_in = emit_final ? ST_LOAD : ST_EMIT_RD;
         default:     state_in = ST_LOAD;
      endcase
   end

   // memory controls and datapath next values
   always_comb begin
      req_stall    = 1'b1;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      count_in     = count_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      pass_in      = pass_ff;
      emit_idx_in  = emit_idx_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      unique case (state_ff)
         // store arriving words in order, drop them once full
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_accept) begin
               if (count_ff < CNT_MAX) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[IDX_BITS-1:0];
                  wr_data = req_value;
               end
               count_in = count_next;
               if (req_last) begin
                  left_in     = CNT_ONE;
                  right_in    = count_next - CNT_ONE;
                  emit_idx_in = '0;
               end
            end
         end
         // downward pass: carry the larger word toward the left bound
         ST_DN_INIT: begin
            rd_en   = 1'b1;
            rd_addr = right_ff[IDX_BITS-1:0];
            pass_in = right_ff;
         end
         ST_DN_CARRY: begin
            carry_in = rdata_ff;
            rd_en    = 1'b1;
            rd_addr  = pass_m1[IDX_BITS-1:0];
         end
         ST_DN_STEP: begin
            wr_en   = 1'b1;
            wr_addr = pass_ff[IDX_BITS-1:0];
            if (rdata_ff < carry_ff) begin
               wr_data = rdata_ff;
            end else begin
               wr_data  = carry_ff;
               carry_in = rdata_ff;
            end
            if (pass_ff != left_ff) begin
               pass_in = pass_m1;
               rd_en   = 1'b1;
               rd_addr = pass_m2[IDX_BITS-1:0];
            end
         end
         ST_DN_FLUSH: begin
            wr_en   = 1'b1;
            wr_addr = left_m1[IDX_BITS-1:0];
            wr_data = carry_ff;
            left_in = left_p1;
         end
         // upward pass: carry the smaller word toward the right bound
         ST_UP_INIT: begin
            rd_en   = 1'b1;
            rd_addr = left_m1[IDX_BITS-1:0];
            pass_in = left_ff;
         end
         ST_UP_CARRY: begin
            carry_in = rdata_ff;
            rd_en    = 1'b1;
            rd_addr  = pass_ff[IDX_BITS-1:0];
         end
         ST_UP_STEP: begin
            wr_en   = 1'b1;
            wr_addr = pass_m1[IDX_BITS-1:0];
            if (carry_ff < rdata_ff) begin
               wr_data = rdata_ff;
            end else begin
               wr_data  = carry_ff;
               carry_in = rdata_ff;
            end
            if (pass_ff != right_ff) begin
               pass_in = pass_p1;
               rd_en   = 1'b1;
               rd_addr = pass_p1[IDX_BITS-1:0];
            end
         end
         ST_UP_FLUSH: begin
            wr_en    = 1'b1;
            wr_addr  = right_ff[IDX_BITS-1:0];
            wr_data  = carry_ff;
            right_in = right_m1;
         end
         // fetch the next sorted word once the output register is free
         ST_EMIT_RD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rd_en   = 1'b1;
               rd_addr = emit_idx_ff;
            end
         end
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rdata_ff;
            rsp_final_in = emit_final;
            if (emit_final) begin
               count_in = '0;
               left_in  = CNT_ONE;
               right_in = '0;
               pass_in  = '0;
            end else begin
               emit_idx_in = emit_idx_ff + IDX_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // memory write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         left_ff      <= CNT_ONE;
         right_ff     <= '0;
         pass_ff      <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         pass_ff      <= pass_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      carry_ff     <= carry_in;
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_res    = rsp_final_ff;

   // a read never targets the entry being written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("memory read and write collide on one entry");

   // compare steps stay inside the current pass bounds
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_STEP || state_ff == ST_UP_STEP) |->
         (pass_ff >= left_ff && pass_ff <= right_ff && left_ff != '0))
      else $error("compare step outside pass bounds");

   // element count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("element count beyond store depth");

   // a result is loaded only into an empty output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD) |-> !rsp_valid_ff)
      else $error("output register overwritten");

endmodule

// ----- tb/sv/cocktail_sort_descending_test.sv -----
module cocktail_sort_descending_test;
   import csd_pkg::*;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
   } in_word_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  fin;
   } sorted_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_sorted_value;
   logic                  rsp_final_res;

   in_word_type           pending_words [$];
   sorted_word_type       expected_sorted [$];
   logic [VALUE_BITS-1:0] held_values [$];

   int words_total = 0;
   int words_accepted = 0;
   int failures = 0;
   int send_wait = 0;
   int send_quiet = 0;
   int recv_wait = 0;
   int recv_quiet = 0;

   cocktail_sort_descending dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res)
   );

   always #6 clock = ~clock;

   // idle draw with occasional stretches of back-to-back traffic
   function automatic int draw_idle(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(8, 40);
      return $urandom_range(0, 16);
   endfunction

   task automatic add_word(input logic [VALUE_BITS-1:0] v, input logic is_last);
      in_word_type w;
      w.value = v;
      w.last  = is_last;
      pending_words.push_back(w);
   endtask

   // keep the set; on its last word rank it largest first and queue the results
   task automatic absorb_word(input logic [VALUE_BITS-1:0] v, input logic is_last);
      logic [VALUE_BITS-1:0] ranked [MAX_ELEMENTS];
      logic [VALUE_BITS-1:0] key;
      sorted_word_type       s;
      int                    n;
      int                    i;
      int                    j;
      if (held_values.size() < MAX_ELEMENTS) held_values.push_back(v);
      if (is_last) begin
         n = held_values.size();
         for (i = 0; i < n; i++) begin
            key = held_values[i];
            j = i;
            while (j > 0 && ranked[j-1] < key) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = key;
         end
         for (i = 0; i < n; i++) begin
            s.value = ranked[i];
            s.fin   = (i == n - 1);
            expected_sorted.push_back(s);
         end
         held_values.delete();
      end
   endtask

   // request driver
   always @(posedge clock) begin
      in_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = draw_idle(send_quiet);
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            absorb_word(req_value, req_last);
            words_accepted++;
            send_wait = draw_idle(send_quiet);
         end
         if (send_wait == 0 && pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_value <= w.value;
            req_last  <= w.last;
         end else begin
            req_valid <= 1'b0;
            if (send_wait > 0) send_wait--;
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      sorted_word_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sorted.size() == 0) begin
               $error("unexpected word: sorted_value %h final_res %b",
                      rsp_sorted_value, rsp_final_res);
               failures++;
            end else begin
               e = expected_sorted.pop_front();
               if (rsp_sorted_value !== e.value) begin
                  $error("sorted_value: expected %h, actual %h", e.value, rsp_sorted_value);
                  failures++;
               end
               if (rsp_final_res !== e.fin) begin
                  $error("final_res: expected %b, actual %b", e.fin, rsp_final_res);
                  failures++;
               end
            end
            recv_wait = draw_idle(recv_quiet);
         end
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int set_len;
      int style;
      int k;
      logic [VALUE_BITS-1:0] v;

      // single element sets at both extremes
      add_word('1, 1'b1);
      add_word('0, 1'b1);
      // short set needing reordering
      add_word(16'h0000, 1'b0);
      add_word(16'h0001, 1'b0);
      add_word(16'hffff, 1'b1);
      // ascending set that overflows the store, with duplicates; last two words are dropped
      for (k = 0; k < 18; k++) add_word(16'(k / 2 * 16'h1111), k == 17);

      // random sets
      while (pending_words.size() < 430) begin
         style = $urandom_range(0, 9);
         if (style == 0) set_len = $urandom_range(17, 22);
         else if (style < 3) set_len = $urandom_range(1, 3);
         else set_len = $urandom_range(2, 16);
         style = $urandom_range(0, 3);
         for (k = 0; k < set_len; k++) begin
            case (style)
               0: v = VALUE_BITS'($urandom_range(0, 3));
               1: v = ($urandom_range(0, 1) != 0) ? '1 :
                      VALUE_BITS'($urandom_range(0, 65535));
               default: v = VALUE_BITS'($urandom_range(0, 65535));
            endcase
            add_word(v, k == set_len - 1);
         end
      end
      words_total = pending_words.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < words_total || expected_sorted.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (failures == 0) begin
         $display("cocktail_sort_descending_test OK");
      end else begin
         $display("cocktail_sort_descending_test NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 200000);
      $display("cocktail_sort_descending_test NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/csd_pkg.sv
rtl/core/cocktail_sort_descending.sv
tb/sv/cocktail_sort_descending_test.sv
